@@ rtl/core/mesh_element_tetra_split_unit_defines.svh @@
// ----------------------------------------------------------------------------
// mesh_element_tetra_split_unit_defines
// assertion macros used by the piece sequencer of the split unit
// ----------------------------------------------------------------------------
`ifndef MESH_ELEMENT_TETRA_SPLIT_UNIT_DEFINES_SVH
`define MESH_ELEMENT_TETRA_SPLIT_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/tsu_pkg.sv @@
// ----------------------------------------------------------------------------
// tsu_pkg
// types, constants and piece tables of the tetrahedral split unit
// ----------------------------------------------------------------------------
package tsu_pkg;

    localparam int VERTEX_W      = 32;
    localparam int NUM_CORNERS   = 8;
    localparam int PRISM_CORNERS = 6;
    localparam int PIECE_W       = 3;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_QUAD  = 2'd1,
        ACT_PRISM = 2'd2,
        ACT_HEX   = 2'd3
    } t_action;

    typedef logic [2:0]          t_corner_idx;
    typedef logic [PIECE_W-1:0]  t_piece;
    typedef logic [VERTEX_W-1:0] t_vertex;

    // one accepted element, indices already cut to the compare width
    typedef struct packed {
        t_action                      action;
        logic                         odd;
        logic [NUM_CORNERS-1:0][VERTEX_W-1:0] v;
    } t_item;

    // element after prism rotation; variant is the split choice for a prism
    // and the parity for a hexahedron
    typedef struct packed {
        t_action                      action;
        logic                         variant;
        logic [NUM_CORNERS-1:0][VERTEX_W-1:0] corner;
    } t_elem;

    typedef struct packed {
        t_corner_idx a;
        t_corner_idx b;
        t_corner_idx c;
        t_corner_idx d;
        logic        d_zero;
        logic        last;
    } t_piece_map;

    // row = lead corner, entry = source corner for each rotated position
    localparam t_corner_idx PRISM_ROT [PRISM_CORNERS][PRISM_CORNERS] = '{
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
        '{3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3},
        '{3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4},
        '{3'd3, 3'd5, 3'd4, 3'd0, 3'd2, 3'd1},
        '{3'd4, 3'd3, 3'd5, 3'd1, 3'd0, 3'd2},
        '{3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0}
    };

    function automatic t_piece_map mk_piece(
        input t_corner_idx a,
        input t_corner_idx b,
        input t_corner_idx c,
        input t_corner_idx d,
        input logic        d_zero,
        input logic        last
    );
        t_piece_map m;
        m.a      = a;
        m.b      = b;
        m.c      = c;
        m.d      = d;
        m.d_zero = d_zero;
        m.last   = last;
        return m;
    endfunction

    function automatic t_piece piece_count(input t_action action);
        t_piece n;
        case (action)
            ACT_PASS:  n = 3'd1;
            ACT_QUAD:  n = 3'd2;
            ACT_PRISM: n = 3'd3;
            default:   n = 3'd5;
        endcase
        return n;
    endfunction

    // corner selection for one simplex of an element
    function automatic t_piece_map piece_map(
        input t_action action,
        input logic    variant,
        input t_piece  piece
    );
        t_piece_map m;
        m = mk_piece(3'd0, 3'd1, 3'd2, 3'd3, 1'b0, 1'b1);
        case (action)
            ACT_PASS: begin
                m = mk_piece(3'd0, 3'd1, 3'd2, 3'd3, 1'b0, 1'b1);
            end
            ACT_QUAD: begin
                case (piece)
                    3'd0:    m = mk_piece(3'd0, 3'd1, 3'd2, 3'd0, 1'b1, 1'b0);
                    default: m = mk_piece(3'd0, 3'd2, 3'd3, 3'd0, 1'b1, 1'b1);
                endcase
            end
            ACT_PRISM: begin
                case ({variant, piece})
                    4'b1_000: m = mk_piece(3'd0, 3'd1, 3'd2, 3'd4, 1'b0, 1'b0);
                    4'b1_001: m = mk_piece(3'd0, 3'd4, 3'd2, 3'd5, 1'b0, 1'b0);
                    4'b0_000: m = mk_piece(3'd0, 3'd1, 3'd2, 3'd5, 1'b0, 1'b0);
                    4'b0_001: m = mk_piece(3'd0, 3'd1, 3'd5, 3'd4, 1'b0, 1'b0);
                    default:  m = mk_piece(3'd0, 3'd4, 3'd5, 3'd3, 1'b0, 1'b1);
                endcase
            end
            default: begin
                case ({variant, piece})
                    4'b0_000: m = mk_piece(3'd0, 3'd1, 3'd3, 3'd4, 1'b0, 1'b0);
                    4'b0_001: m = mk_piece(3'd1, 3'd2, 3'd3, 3'd6, 1'b0, 1'b0);
                    4'b0_010: m = mk_piece(3'd3, 3'd4, 3'd6, 3'd7, 1'b0, 1'b0);
                    4'b0_011: m = mk_piece(3'd1, 3'd4, 3'd5, 3'd6, 1'b0, 1'b0);
                    4'b0_100: m = mk_piece(3'd1, 3'd3, 3'd4, 3'd6, 1'b0, 1'b1);
                    4'b1_000: m = mk_piece(3'd0, 3'd2, 3'd3, 3'd7, 1'b0, 1'b0);
                    4'b1_001: m = mk_piece(3'd0, 3'd1, 3'd2, 3'd5, 1'b0, 1'b0);
                    4'b1_010: m = mk_piece(3'd2, 3'd5, 3'd6, 3'd7, 1'b0, 1'b0);
                    4'b1_011: m = mk_piece(3'd5, 3'd4, 3'd7, 3'd0, 1'b0, 1'b0);
                    4'b1_100: m = mk_piece(3'd5, 3'd2, 3'd0, 3'd7, 1'b0, 1'b1);
                    default:  m = mk_piece(3'd0, 3'd1, 3'd2, 3'd3, 1'b0, 1'b1);
                endcase
            end
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/mesh_element_tetra_split_unit.sv @@
// ----------------------------------------------------------------------------
// mesh_element_tetra_split_unit
// splits pass-through, quad, prism and hexahedron elements into simplices
// ----------------------------------------------------------------------------
// The unit takes one element per input transaction and gives its simplices one
// per output transaction, in order, with o_last on the final one. A pass-through
// gives one simplex, a quad two, a prism three and a hexahedron five. The output
// register takes one simplex per cycle while i_out_ready does not stall it, and
// the next element is taken while the previous one is still being emitted, so
// there are no gaps between elements. The first simplex of an element passes the
// input register, then the element register, then the output register. Vertex
// indices are compared and emitted at INDEX_BITS, or 32 bits if that is smaller.
module mesh_element_tetra_split_unit
    import tsu_pkg::*;
#(
    parameter int INDEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic                i_odd_element,
    input  logic [VERTEX_W-1:0] i_v1,
    input  logic [VERTEX_W-1:0] i_v2,
    input  logic [VERTEX_W-1:0] i_v3,
    input  logic [VERTEX_W-1:0] i_v4,
    input  logic [VERTEX_W-1:0] i_v5,
    input  logic [VERTEX_W-1:0] i_v6,
    input  logic [VERTEX_W-1:0] i_v7,
    input  logic [VERTEX_W-1:0] i_v8,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [VERTEX_W-1:0] o_corner_a,
    output logic [VERTEX_W-1:0] o_corner_b,
    output logic [VERTEX_W-1:0] o_corner_c,
    output logic [VERTEX_W-1:0] o_corner_d,
    output logic [PIECE_W-1:0]  o_piece,
    output logic                o_last
);

    localparam int CMP_W = (INDEX_BITS < VERTEX_W) ? INDEX_BITS : VERTEX_W;
    localparam logic [VERTEX_W-1:0] IDX_MASK = {VERTEX_W{1'b1}} >> (VERTEX_W - CMP_W);

    logic  r_in_valid, n_in_valid;
    t_item r_item, n_item;
    t_elem prep_elem;
    logic  seq_ready;
    logic  in_fire;
    logic  seq_take;

    assign seq_take   = r_in_valid && seq_ready;
    assign o_in_ready = !r_in_valid || seq_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_item.action = t_action'(i_action);
        n_item.odd    = i_odd_element;
        n_item.v[0]   = i_v1 & IDX_MASK;
        n_item.v[1]   = i_v2 & IDX_MASK;
        n_item.v[2]   = i_v3 & IDX_MASK;
        n_item.v[3]   = i_v4 & IDX_MASK;
        n_item.v[4]   = i_v5 & IDX_MASK;
        n_item.v[5]   = i_v6 & IDX_MASK;
        n_item.v[6]   = i_v7 & IDX_MASK;
        n_item.v[7]   = i_v8 & IDX_MASK;

        n_in_valid = r_in_valid;
        if (in_fire) begin
            n_in_valid = 1'b1;
        end else if (seq_take) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= n_item;
        end
    end

    tsu_prism_prep u_prep (
        .i_item (r_item),
        .o_elem (prep_elem)
    );

    tsu_piece_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .o_ready    (seq_ready),
        .i_elem     (prep_elem),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_corner_a (o_corner_a),
        .o_corner_b (o_corner_b),
        .o_corner_c (o_corner_c),
        .o_corner_d (o_corner_d),
        .o_piece    (o_piece),
        .o_last     (o_last)
    );

endmodule

@@ rtl/core/tsu_prism_prep.sv @@
// ----------------------------------------------------------------------------
// tsu_prism_prep
// prism lead search, rotation and diagonal choice from pairwise compares
// ----------------------------------------------------------------------------
module tsu_prism_prep
    import tsu_pkg::*;
(
    input  t_item i_item,
    output t_elem o_elem
);

    logic [PRISM_CORNERS-1:0][PRISM_CORNERS-1:0] lt;
    logic [PRISM_CORNERS-1:0] is_lead;
    logic [PRISM_CORNERS-1:0] split35;
    logic [PRISM_CORNERS-1:0][VERTEX_W-1:0] rot;
    logic split_sel;

    // lt[i][j]: corner i strictly below corner j, all compares in parallel
    always_comb begin
        for (int i = 0; i < PRISM_CORNERS; i++) begin
            for (int j = 0; j < PRISM_CORNERS; j++) begin
                lt[i][j] = i_item.v[i] < i_item.v[j];
            end
        end
    end

    // lead is the first corner holding the smallest index
    always_comb begin
        for (int i = 0; i < PRISM_CORNERS; i++) begin
            is_lead[i] = 1'b1;
            for (int j = 0; j < PRISM_CORNERS; j++) begin
                if (j < i && !lt[i][j]) begin
                    is_lead[i] = 1'b0;
                end
                if (j > i && lt[j][i]) begin
                    is_lead[i] = 1'b0;
                end
            end
        end
    end

    // min(p3,p5) < min(p2,p6) as (p3<p2 | p5<p2) & (p3<p6 | p5<p6)
    always_comb begin
        for (int i = 0; i < PRISM_CORNERS; i++) begin
            split35[i] = (lt[PRISM_ROT[i][2]][PRISM_ROT[i][1]]
                          || lt[PRISM_ROT[i][4]][PRISM_ROT[i][1]])
                      && (lt[PRISM_ROT[i][2]][PRISM_ROT[i][5]]
                          || lt[PRISM_ROT[i][4]][PRISM_ROT[i][5]]);
        end
        split_sel = |(is_lead & split35);
    end

    always_comb begin
        for (int k = 0; k < PRISM_CORNERS; k++) begin
            rot[k] = '0;
            for (int i = 0; i < PRISM_CORNERS; i++) begin
                rot[k] = rot[k] | ({VERTEX_W{is_lead[i]}} & i_item.v[PRISM_ROT[i][k]]);
            end
        end
    end

    always_comb begin
        o_elem.action  = i_item.action;
        o_elem.variant = i_item.odd;
        o_elem.corner  = i_item.v;
        if (i_item.action == ACT_PRISM) begin
            o_elem.variant = split_sel;
            for (int k = 0; k < PRISM_CORNERS; k++) begin
                o_elem.corner[k] = rot[k];
            end
        end
    end

endmodule

@@ rtl/core/tsu_piece_seq.sv @@
// ----------------------------------------------------------------------------
// tsu_piece_seq
// element register with piece counter, feeding the simplex output register
// ----------------------------------------------------------------------------
`include "mesh_element_tetra_split_unit_defines.svh"

module tsu_piece_seq
    import tsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_elem   i_elem,
    output logic    o_valid,
    input  logic    i_ready,
    output t_vertex o_corner_a,
    output t_vertex o_corner_b,
    output t_vertex o_corner_c,
    output t_vertex o_corner_d,
    output t_piece  o_piece,
    output logic    o_last
);

    logic       r_seq_valid, n_seq_valid;
    t_piece     r_piece, n_piece;
    t_action    r_action;
    logic       r_variant;
    logic [NUM_CORNERS-1:0][VERTEX_W-1:0] r_corner;

    logic       r_out_valid, n_out_valid;
    t_vertex    r_out_a, r_out_b, r_out_c, r_out_d;
    t_piece     r_out_piece;
    logic       r_out_last;

    t_piece_map map;
    logic       out_ld;
    logic       seq_adv;
    logic       seq_ld;

    assign map     = piece_map(r_action, r_variant, r_piece);
    assign out_ld  = !r_out_valid || i_ready;
    assign seq_adv = r_seq_valid && out_ld;
    assign o_ready = !r_seq_valid || (seq_adv && map.last);
    assign seq_ld  = i_valid && o_ready;

    always_comb begin
        n_seq_valid = r_seq_valid;
        n_piece     = r_piece;
        if (seq_ld) begin
            n_seq_valid = 1'b1;
            n_piece     = '0;
        end else if (seq_adv) begin
            if (map.last) begin
                n_seq_valid = 1'b0;
            end else begin
                n_piece = r_piece + 1'b1;
            end
        end
        n_out_valid = out_ld ? r_seq_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
            r_piece     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq_valid <= n_seq_valid;
            r_piece     <= n_piece;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_ld) begin
            r_action  <= i_elem.action;
            r_variant <= i_elem.variant;
            r_corner  <= i_elem.corner;
        end
        if (seq_adv) begin
            r_out_a     <= r_corner[map.a];
            r_out_b     <= r_corner[map.b];
            r_out_c     <= r_corner[map.c];
            r_out_d     <= map.d_zero ? '0 : r_corner[map.d];
            r_out_piece <= r_piece;
            r_out_last  <= map.last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_corner_a = r_out_a;
    assign o_corner_b = r_out_b;
    assign o_corner_c = r_out_c;
    assign o_corner_d = r_out_d;
    assign o_piece    = r_out_piece;
    assign o_last     = r_out_last;

    `TSU_ASSERT_NOW(a_piece_in_range, r_seq_valid, r_piece < piece_count(r_action), "piece counter ran past the element")
    `TSU_ASSERT_NEXT(a_piece_follows, r_out_valid && i_ready && !r_out_last, r_out_valid && (r_out_piece == $past(r_out_piece) + 1'b1), "simplex run broken before its last piece")
    `TSU_ASSERT_NEXT(a_seq_drains, seq_adv && map.last && !i_valid, !r_seq_valid, "element register kept after its last piece")
    `TSU_ASSERT_NOW(a_no_load_busy, seq_ld && r_seq_valid, seq_adv && map.last, "element overwritten while pieces remain")

endmodule

@@ tb/mesh_element_tetra_split_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_element_tetra_split_unit_test
// checks the simplex stream of the tetrahedral split unit
// ----------------------------------------------------------------------------
// Elements of every kind are sent through the input channel, a directed set
// first and then random ones, with random idle bursts on the input and random
// ready stalls on the output. At each accepted element the bench computes the
// simplices that the element splits into and queues them; every accepted output
// transaction is compared field by field with the oldest queued simplex.
// ----------------------------------------------------------------------------
module mesh_element_tetra_split_unit_test;
    import tsu_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ELEMS = 200;
    localparam int CALM_TAIL    = 24;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;

    // source corner for each rotated prism position, one row per lead corner
    localparam int LEAD_ROTATION [6][6] = '{
        '{0, 1, 2, 3, 4, 5},
        '{1, 2, 0, 4, 5, 3},
        '{2, 0, 1, 5, 3, 4},
        '{3, 5, 4, 0, 2, 1},
        '{4, 3, 5, 1, 0, 2},
        '{5, 4, 3, 2, 1, 0}
    };

    typedef struct packed {
        t_action                  kind;
        logic                     odd;
        logic [7:0][VERTEX_W-1:0] corner;
    } t_element;

    typedef struct packed {
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
        logic [VERTEX_W-1:0] c;
        logic [VERTEX_W-1:0] d;
        logic [PIECE_W-1:0]  piece;
        logic                last;
    } t_simplex;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_action      = 2'd0;
    logic                i_odd_element = 1'b0;
    logic [VERTEX_W-1:0] i_v1          = '0;
    logic [VERTEX_W-1:0] i_v2          = '0;
    logic [VERTEX_W-1:0] i_v3          = '0;
    logic [VERTEX_W-1:0] i_v4          = '0;
    logic [VERTEX_W-1:0] i_v5          = '0;
    logic [VERTEX_W-1:0] i_v6          = '0;
    logic [VERTEX_W-1:0] i_v7          = '0;
    logic [VERTEX_W-1:0] i_v8          = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [VERTEX_W-1:0] o_corner_a;
    logic [VERTEX_W-1:0] o_corner_b;
    logic [VERTEX_W-1:0] o_corner_c;
    logic [VERTEX_W-1:0] o_corner_d;
    logic [PIECE_W-1:0]  o_piece;
    logic                o_last;

    t_element            pending_elems [$];
    t_simplex            expected_simplices [$];
    t_element            cur_elem;
    t_simplex            got;
    t_simplex            want;
    logic [VERTEX_W-1:0] corners [8];
    logic                tail_phase     = 1'b0;
    int                  in_gap         = 0;
    int                  out_stall      = 0;
    int                  elems_total    = 0;
    int                  elems_accepted = 0;
    int                  simplices_seen = 0;
    int                  mismatch_count = 0;
    int                  idle_cycles    = 0;
    int                  kind_count [4] = '{0, 0, 0, 0};
    int                  mode;

    mesh_element_tetra_split_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_odd_element (i_odd_element),
        .i_v1          (i_v1),
        .i_v2          (i_v2),
        .i_v3          (i_v3),
        .i_v4          (i_v4),
        .i_v5          (i_v5),
        .i_v6          (i_v6),
        .i_v7          (i_v7),
        .i_v8          (i_v8),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_corner_a    (o_corner_a),
        .o_corner_b    (o_corner_b),
        .o_corner_c    (o_corner_c),
        .o_corner_d    (o_corner_d),
        .o_piece       (o_piece),
        .o_last        (o_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic void queue_elem(
        input t_action             kind,
        input logic                odd,
        input logic [VERTEX_W-1:0] c1, c2, c3, c4, c5, c6, c7, c8
    );
        t_element e;
        e.kind   = kind;
        e.odd    = odd;
        e.corner = {c8, c7, c6, c5, c4, c3, c2, c1};
        pending_elems.push_back(e);
    endfunction

    function automatic void add_simplex(
        input int                  k,
        input logic [VERTEX_W-1:0] a, b, c, d
    );
        t_simplex s;
        s.a     = a;
        s.b     = b;
        s.c     = c;
        s.d     = d;
        s.piece = k[PIECE_W-1:0];
        s.last  = 1'b0;
        expected_simplices.push_back(s);
    endfunction

    // queues the simplices that one element splits into
    function automatic void split_element(input t_element e);
        logic [VERTEX_W-1:0] v [8];
        logic [VERTEX_W-1:0] p [6];
        logic [VERTEX_W-1:0] min26;
        logic [VERTEX_W-1:0] min35;
        int                  lead;
        for (int i = 0; i < 8; i++) begin
            v[i] = e.corner[i];
        end
        case (e.kind)
            ACT_PASS: begin
                add_simplex(0, v[0], v[1], v[2], v[3]);
            end
            ACT_QUAD: begin
                add_simplex(0, v[0], v[1], v[2], '0);
                add_simplex(1, v[0], v[2], v[3], '0);
            end
            ACT_PRISM: begin
                // lowest corner number wins a tie for the smallest index
                lead = 0;
                for (int i = 1; i < 6; i++) begin
                    if (v[i] < v[lead]) begin
                        lead = i;
                    end
                end
                for (int i = 0; i < 6; i++) begin
                    p[i] = v[LEAD_ROTATION[lead][i]];
                end
                min26 = (p[1] < p[5]) ? p[1] : p[5];
                min35 = (p[2] < p[4]) ? p[2] : p[4];
                if (min35 < min26) begin
                    add_simplex(0, p[0], p[1], p[2], p[4]);
                    add_simplex(1, p[0], p[4], p[2], p[5]);
                end else begin
                    add_simplex(0, p[0], p[1], p[2], p[5]);
                    add_simplex(1, p[0], p[1], p[5], p[4]);
                end
                add_simplex(2, p[0], p[4], p[5], p[3]);
            end
            default: begin
                if (!e.odd) begin
                    add_simplex(0, v[0], v[1], v[3], v[4]);
                    add_simplex(1, v[1], v[2], v[3], v[6]);
                    add_simplex(2, v[3], v[4], v[6], v[7]);
                    add_simplex(3, v[1], v[4], v[5], v[6]);
                    add_simplex(4, v[1], v[3], v[4], v[6]);
                end else begin
                    add_simplex(0, v[0], v[2], v[3], v[7]);
                    add_simplex(1, v[0], v[1], v[2], v[5]);
                    add_simplex(2, v[2], v[5], v[6], v[7]);
                    add_simplex(3, v[5], v[4], v[7], v[0]);
                    add_simplex(4, v[5], v[2], v[0], v[7]);
                end
            end
        endcase
        expected_simplices[expected_simplices.size() - 1].last = 1'b1;
    endfunction

    // element driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                split_element(cur_elem);
                kind_count[cur_elem.kind]++;
                elems_accepted++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_elems.size() > 0) begin
                    cur_elem = pending_elems.pop_front();
                    i_in_valid    <= 1'b1;
                    i_action      <= cur_elem.kind;
                    i_odd_element <= cur_elem.odd;
                    i_v1          <= cur_elem.corner[0];
                    i_v2          <= cur_elem.corner[1];
                    i_v3          <= cur_elem.corner[2];
                    i_v4          <= cur_elem.corner[3];
                    i_v5          <= cur_elem.corner[4];
                    i_v6          <= cur_elem.corner[5];
                    i_v7          <= cur_elem.corner[6];
                    i_v8          <= cur_elem.corner[7];
                    if (!tail_phase && $urandom_range(0, 4) == 0) begin
                        in_gap = $urandom_range(1, 11);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            tail_phase <= (pending_elems.size() <= CALM_TAIL);
        end
    end

    // simplex monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                simplices_seen++;
                got = '{o_corner_a, o_corner_b, o_corner_c, o_corner_d, o_piece, o_last};
                if (expected_simplices.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] unexpected simplex: a=%h b=%h c=%h d=%h piece=%0d last=%0b",
                                 $time, got.a, got.b, got.c, got.d, got.piece, got.last);
                    end
                end else begin
                    want = expected_simplices.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] simplex mismatch", $time);
                            $display("    expected a=%h b=%h c=%h d=%h piece=%0d last=%0b",
                                     want.a, want.b, want.c, want.d, want.piece, want.last);
                            $display("    actual   a=%h b=%h c=%h d=%h piece=%0d last=%0b",
                                     got.a, got.b, got.c, got.d, got.piece, got.last);
                        end
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!tail_phase && $urandom_range(0, 5) == 0) begin
                    out_stall = $urandom_range(1, 11);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        // extremes of the pass-through, quad and hexahedron kinds, unused corners loaded with noise
        queue_elem(ACT_PASS, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_elem(ACT_PASS, 1'b1, '1, '1, '1, '1, 32'h1234_5678, '1, '0, '1);
        queue_elem(ACT_QUAD, 1'b1, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_FFFE, '1, '1, '1, '1);
        queue_elem(ACT_QUAD, 1'b0, '1, '1, '1, '1, '0, '0, '0, '0);
        queue_elem(ACT_HEX, 1'b0, 32'd11, 32'd22, 32'd33, 32'd44, 32'd55, 32'd66,
                   32'd77, 32'd88);
        queue_elem(ACT_HEX, 1'b1, 32'd11, 32'd22, 32'd33, 32'd44, 32'd55, 32'd66,
                   32'd77, 32'd88);
        queue_elem(ACT_HEX, 1'b0, '1, '0, '1, '0, '1, '0, '1, '0);
        queue_elem(ACT_HEX, 1'b1, '0, '1, '0, '1, '0, '1, '0, '1);
        // prism with the smallest index on each corner in turn
        for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 8; i++) begin
                corners[i] = 32'd40 + 32'd10 * i;
            end
            corners[k] = 32'd3;
            queue_elem(ACT_PRISM, k[0], corners[0], corners[1], corners[2], corners[3],
                       corners[4], corners[5], '1, '1);
        end
        // all corners equal: lead stays on corner one, diagonal tie
        queue_elem(ACT_PRISM, 1'b0, '1, '1, '1, '1, '1, '1, '0, '0);
        // tie for the smallest index between corners three and five
        queue_elem(ACT_PRISM, 1'b1, 32'd9, 32'd8, 32'd2, 32'd7, 32'd2, 32'd6, '0, '1);
        // 3-5 diagonal strictly smaller
        queue_elem(ACT_PRISM, 1'b0, 32'd1, 32'd10, 32'd5, 32'd20, 32'd6, 32'd30, '0, '0);
        // diagonal minima equal, so the 2-6 split
        queue_elem(ACT_PRISM, 1'b0, 32'd1, 32'd5, 32'd5, 32'd20, 32'd9, 32'd30, '0, '0);
        queue_elem(ACT_PRISM, 1'b1, '0, '1, 32'hFFFF_FFFE, '1, 32'hFFFF_FFFD, '1, '1, '1);

        for (int n = 0; n < RANDOM_ELEMS; n++) begin
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 8; i++) begin
                if (mode < 5) begin
                    corners[i] = $urandom;
                end else if (mode < 8) begin
                    // narrow range so prism ties come up often
                    corners[i] = $urandom_range(0, 7);
                end else begin
                    corners[i] = 32'hFFFF_FFF0 | $urandom_range(0, 15);
                end
            end
            queue_elem(t_action'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       corners[0], corners[1], corners[2], corners[3],
                       corners[4], corners[5], corners[6], corners[7]);
        end
        elems_total = pending_elems.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (elems_accepted < elems_total || expected_simplices.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d elements: %0d pass-through, %0d quad, %0d prism, %0d hexahedron",
                 elems_accepted, kind_count[ACT_PASS], kind_count[ACT_QUAD],
                 kind_count[ACT_PRISM], kind_count[ACT_HEX]);
        $display("checked %0d simplices, %0d mismatches, %0d still expected",
                 simplices_seen, mismatch_count, expected_simplices.size());
        if (mismatch_count == 0 && expected_simplices.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/tsu_pkg.sv
rtl/core/tsu_prism_prep.sv
rtl/core/tsu_piece_seq.sv
rtl/core/mesh_element_tetra_split_unit.sv
tb/mesh_element_tetra_split_unit_test.sv
